FILE: hdl/schid_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// schid_pkg
// Types, codes and lookup tables for the scan code to HID report block.
// ---------------------------------------------------------------------------
package schid_pkg;

    localparam logic [1:0] KIND_BUTTON    = 2'd0;
    localparam logic [1:0] KIND_ATTENTION = 2'd1;
    localparam logic [1:0] KIND_KEYBOARD  = 2'd2;

    localparam logic [7:0] CODE_ATTENTION = 8'h58;
    localparam logic [7:0] CODE_PAUSE     = 8'h45;
    localparam logic [7:0] CODE_PRT_A     = 8'h2a;
    localparam logic [7:0] CODE_PRT_B     = 8'h37;
    localparam logic [7:0] CODE_F1        = 8'h3b;
    localparam logic [7:0] CODE_F10       = 8'h44;
    localparam logic [7:0] CODE_F11       = 8'h57;
    localparam logic [7:0] USAGE_PAUSE    = 8'h48;
    localparam logic [7:0] USAGE_PRTSC    = 8'h46;
    localparam logic [7:0] USAGE_MOD_LO   = 8'he0;
    localparam logic [7:0] USAGE_MOD_HI   = 8'he7;

    // Classified event handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  kind;     // report kind for a report that goes out
        logic        none;     // no report (decided early)
        logic        brk;
        logic [7:0]  usage;    // keyboard usage; zero for attention and button events
        logic [11:0] buttons;  // button word for a button report
    } event_t;

    function automatic logic [7:0] base_usage(input logic [7:0] c);
        logic [7:0] u;
        case (c)
            8'h01: u = 8'h29; 8'h02: u = 8'h1e; 8'h03: u = 8'h1f; 8'h04: u = 8'h20;
            8'h05: u = 8'h21; 8'h06: u = 8'h22; 8'h07: u = 8'h23; 8'h08: u = 8'h24;
            8'h09: u = 8'h25; 8'h0a: u = 8'h26; 8'h0b: u = 8'h27; 8'h0c: u = 8'h2d;
            8'h0d: u = 8'h2e; 8'h0e: u = 8'h2a; 8'h0f: u = 8'h2b; 8'h10: u = 8'h14;
            8'h11: u = 8'h1a; 8'h12: u = 8'h08; 8'h13: u = 8'h15; 8'h14: u = 8'h17;
            8'h15: u = 8'h1c; 8'h16: u = 8'h18; 8'h17: u = 8'h0c; 8'h18: u = 8'h12;
            8'h19: u = 8'h13; 8'h1a: u = 8'h2f; 8'h1b: u = 8'h30; 8'h1c: u = 8'h28;
            8'h1d: u = 8'he0; 8'h1e: u = 8'h04; 8'h1f: u = 8'h16; 8'h20: u = 8'h07;
            8'h21: u = 8'h09; 8'h22: u = 8'h0a; 8'h23: u = 8'h0b; 8'h24: u = 8'h0d;
            8'h25: u = 8'h0e; 8'h26: u = 8'h0f; 8'h27: u = 8'h33; 8'h28: u = 8'h34;
            8'h29: u = 8'h35; 8'h2a: u = 8'he1; 8'h2b: u = 8'h31; 8'h2c: u = 8'h1d;
            8'h2d: u = 8'h1b; 8'h2e: u = 8'h06; 8'h2f: u = 8'h19; 8'h30: u = 8'h05;
            8'h31: u = 8'h11; 8'h32: u = 8'h10; 8'h33: u = 8'h36; 8'h34: u = 8'h37;
            8'h35: u = 8'h38; 8'h36: u = 8'he5; 8'h37: u = 8'h55; 8'h38: u = 8'he2;
            8'h39: u = 8'h2c; 8'h3a: u = 8'h39; 8'h3b: u = 8'h3a; 8'h3c: u = 8'h3b;
            8'h3d: u = 8'h3c; 8'h3e: u = 8'h3d; 8'h3f: u = 8'h3e; 8'h40: u = 8'h3f;
            8'h41: u = 8'h40; 8'h42: u = 8'h41; 8'h43: u = 8'h42; 8'h44: u = 8'h43;
            8'h45: u = 8'h53; 8'h46: u = 8'h47; 8'h47: u = 8'h5f; 8'h48: u = 8'h60;
            8'h49: u = 8'h61; 8'h4a: u = 8'h56; 8'h4b: u = 8'h5c; 8'h4c: u = 8'h5d;
            8'h4d: u = 8'h5e; 8'h4e: u = 8'h57; 8'h4f: u = 8'h59; 8'h50: u = 8'h5a;
            8'h51: u = 8'h5b; 8'h52: u = 8'h62; 8'h53: u = 8'h63; 8'h57: u = 8'h44;
            8'h58: u = 8'h45;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

    function automatic logic [7:0] e0_usage(input logic [7:0] c);
        logic [7:0] u;
        case (c)
            8'h52: u = 8'h49; 8'h47: u = 8'h4a; 8'h49: u = 8'h4b; 8'h53: u = 8'h4c;
            8'h4f: u = 8'h4d; 8'h51: u = 8'h4e; 8'h4d: u = 8'h4f; 8'h4b: u = 8'h50;
            8'h50: u = 8'h51; 8'h48: u = 8'h52; 8'h35: u = 8'h54; 8'h1c: u = 8'h58;
            8'h5d: u = 8'h65; 8'h5b: u = 8'he3; 8'h1d: u = 8'he4; 8'h38: u = 8'he6;
            8'h5c: u = 8'he7;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/schid_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// schid_front
// Accepts key events, handles attention and button codes, tracks the prefix
// flags and translates keyboard codes to HID usages.
// ---------------------------------------------------------------------------
module schid_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   kb_enable,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [7:0]            code,
    input  wire                   brk,
    input  wire                   e0,
    input  wire                   e1,
    output logic                  ev_valid,
    input  wire                   ev_ready,
    output schid_pkg::event_t     ev
);
    import schid_pkg::*;

    logic [11:0] buttons_reg, buttons_next;
    logic        e0p_reg, e0p_next, e1p_reg, e1p_next;
    logic [7:0]  usage;
    logic [3:0]  bidx;
    logic        is_button;

    assign in_ready = ev_ready;
    assign ev_valid = in_valid;

    // Classify one event and compute the next prefix and button state.
    always_comb begin
        buttons_next = buttons_reg;
        e0p_next     = e0p_reg;
        e1p_next     = e1p_reg;
        usage        = 8'h00;
        is_button    = 1'b0;
        bidx         = 4'd0;
        if (code >= CODE_F1 && code <= CODE_F10) begin
            is_button = 1'b1;
            bidx      = 4'(code - CODE_F1);
        end else if (code == CODE_F11) begin
            is_button = 1'b1;
            bidx      = 4'd10;
        end
        if (is_button) begin
            buttons_next[bidx] = ~brk;
        end
        ev.kind    = KIND_KEYBOARD;
        ev.none    = 1'b0;
        ev.brk     = brk;
        ev.usage   = 8'h00;
        ev.buttons = buttons_next;
        if (code == CODE_ATTENTION) begin
            ev.kind = KIND_ATTENTION;
        end else if (is_button) begin
            ev.kind = KIND_BUTTON;
        end else if (!kb_enable) begin
            ev.none = 1'b1;
        end else begin
            if (e1) begin
                e1p_next = 1'b1;
            end else if (e0) begin
                if (code == CODE_PRT_A || code == CODE_PRT_B) begin
                    if (!e0p_reg) begin
                        e0p_next = 1'b1;
                    end else begin
                        e0p_next = 1'b0;
                        usage    = USAGE_PRTSC;
                    end
                end else begin
                    usage = e0_usage(code);
                    if (usage == 8'h00) begin
                        e0p_next = 1'b0;
                    end
                end
            end else if (e1p_reg && code == CODE_PAUSE) begin
                e1p_next = 1'b0;
                usage    = USAGE_PAUSE;
            end else begin
                e1p_next = 1'b0;
                usage    = base_usage(code);
            end
            ev.usage = usage;
            ev.none  = (usage == 8'h00);
        end
    end

    // State update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buttons_reg <= '0;
            e0p_reg     <= 1'b0;
            e1p_reg     <= 1'b0;
        end else if (in_valid && in_ready) begin
            buttons_reg <= buttons_next;
            e0p_reg     <= e0p_next;
            e1p_reg     <= e1p_next;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/schid_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// schid_queue
// Two-entry queue of classified events between the front and back parts.
// ---------------------------------------------------------------------------
module schid_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                wr_valid,
    output logic               wr_ready,
    input  schid_pkg::event_t  wr_data,
    output logic               rd_valid,
    input  wire                rd_ready,
    output schid_pkg::event_t  rd_data
);
    import schid_pkg::*;

    event_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // Storage writes.
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/schid_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// schid_back
// Applies keyboard usages to the modifier byte and key slots, searching the
// slots one per cycle, and drives the output report register.
// ---------------------------------------------------------------------------
module schid_back #(
    parameter int KEY_SLOTS = 6
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                ev_valid,
    output logic               ev_ready,
    input  schid_pkg::event_t  ev,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [73:0]        out_data
);
    import schid_pkg::*;

    localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_EMPT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]    st_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    keys_reg [KEY_SLOTS];
    logic [7:0]    mods_reg;
    event_t        cur_reg;
    logic          ovalid_reg;
    logic [73:0]   odata_reg;
    logic          slot_free;
    logic [7:0]    slot_val;
    logic          slot_last;
    logic          ev_mod;
    logic          emit;
    logic [73:0]   emit_data;
    logic [47:0]   slots_flat;

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign slot_free = !ovalid_reg || out_ready;
    assign ev_ready  = (st_reg == ST_IDLE) && slot_free;
    assign slot_val  = keys_reg[idx_reg];
    assign slot_last = (32'(idx_reg) == KEY_SLOTS - 1);
    assign ev_mod    = ev.usage inside {[USAGE_MOD_LO:USAGE_MOD_HI]};

    // Key slots flattened for the report; slots past KEY_SLOTS read zero.
    always_comb begin
        slots_flat = '0;
        for (int i = 0; i < 6; i++) begin
            if (i < KEY_SLOTS) slots_flat[i*8 +: 8] = keys_reg[i];
        end
    end

    // Decide when the output register loads a new beat and with what.
    always_comb begin
        emit      = 1'b0;
        emit_data = '0;
        case (st_reg)
            ST_IDLE: begin
                if (ev_valid && ev_ready) begin
                    if (ev.kind == KIND_ATTENTION) begin
                        emit      = 1'b1;
                        emit_data = {56'd0, (ev.brk ? 3'd0 : 3'd7), 12'd0,
                                     KIND_ATTENTION, 1'b1};
                    end else if (ev.kind == KIND_BUTTON) begin
                        emit      = 1'b1;
                        emit_data = {56'd0, 3'd0, ev.buttons, KIND_BUTTON, 1'b1};
                    end else if (ev.none) begin
                        emit = 1'b1;
                    end else if (ev_mod && !ev.brk && mods_reg[ev.usage[2:0]]) begin
                        emit = 1'b1;
                    end
                end
            end
            ST_SRCH: begin
                if (slot_val == cur_reg.usage) begin
                    emit = !cur_reg.brk && slot_free;
                end else if (slot_last) begin
                    emit = cur_reg.brk && slot_free;
                end
            end
            ST_EMPT: begin
                emit = (slot_val != 8'h00) && slot_last && slot_free;
            end
            ST_OUT: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_data = {slots_flat, mods_reg, 3'd0, 12'd0, KIND_KEYBOARD, 1'b1};
                end
            end
            default: emit = 1'b0;
        endcase
    end

    // Output beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (emit) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            odata_reg <= emit_data;
        end
    end

    // Sequencer and state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            idx_reg  <= '0;
            mods_reg <= 8'h00;
            for (int i = 0; i < KEY_SLOTS; i++) keys_reg[i] <= 8'h00;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (ev_valid && ev_ready) begin
                        cur_reg <= ev;
                        idx_reg <= '0;
                        if (ev.kind == KIND_KEYBOARD && !ev.none) begin
                            if (ev_mod) begin
                                if (ev.brk) begin
                                    mods_reg[ev.usage[2:0]] <= 1'b0;
                                    st_reg <= ST_OUT;
                                end else if (!mods_reg[ev.usage[2:0]]) begin
                                    mods_reg[ev.usage[2:0]] <= 1'b1;
                                    st_reg <= ST_OUT;
                                end
                            end else begin
                                st_reg <= ST_SRCH;
                            end
                        end
                    end
                end
                // Look for a slot that holds the usage.
                ST_SRCH: begin
                    if (slot_val == cur_reg.usage) begin
                        if (cur_reg.brk) begin
                            keys_reg[idx_reg] <= 8'h00;
                            st_reg <= ST_OUT;
                        end else if (slot_free) begin
                            st_reg <= ST_IDLE;
                        end
                    end else if (slot_last) begin
                        if (cur_reg.brk) begin
                            if (slot_free) begin
                                idx_reg <= '0;
                                st_reg  <= ST_IDLE;
                            end
                        end else begin
                            idx_reg <= '0;
                            st_reg  <= ST_EMPT;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // Look for the first empty slot.
                ST_EMPT: begin
                    if (slot_val == 8'h00) begin
                        keys_reg[idx_reg] <= cur_reg.usage;
                        st_reg <= ST_OUT;
                    end else if (slot_last) begin
                        if (slot_free) begin
                            st_reg <= ST_IDLE;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // Emit the keyboard report from the updated state.
                ST_OUT: begin
                    if (slot_free) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/scan_code_to_hid_report_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scan_code_to_hid_report_top
// Set-1 key event to HID button, attention or keyboard report translator.
// ---------------------------------------------------------------------------
// Each accepted beat gives exactly one result beat. Attention, button,
// no-report and repeated-modifier events are answered from the idle state,
// and modifier changes pass through the output state; other keyboard keys
// walk the key slots one per cycle, first for the usage and then, for a new
// key, for an empty slot. A two-entry queue lets the front part accept
// events while the back part works.
module scan_code_to_hid_report_top #(
    parameter int KEY_SLOTS = 6
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // make_code
    input  wire  [2:0]  s_tuser,   // is_break, e0_prefix, e1_prefix
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata    // report_valid, report_kind, button_bits,
                                   // attention_keys, modifier_bits,
                                   // key_slot_0..key_slot_5, zero fill
);
    import schid_pkg::*;

    logic   en_reg;
    logic   fv, fr, bv, br;
    event_t fe, be;
    logic [73:0] od;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'd0, od};

    // Keyboard enable register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b1;
        end else if (cfg_valid) begin
            en_reg <= cfg_data;
        end
    end

    schid_front u_front (
        .aclk(aclk), .aresetn(aresetn), .kb_enable(en_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .code(s_tdata),
        .brk(s_tuser[0]), .e0(s_tuser[1]), .e1(s_tuser[2]),
        .ev_valid(fv), .ev_ready(fr), .ev(fe)
    );

    schid_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fv), .wr_ready(fr), .wr_data(fe),
        .rd_valid(bv), .rd_ready(br), .rd_data(be)
    );

    schid_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .ev_valid(bv), .ev_ready(br), .ev(be),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
    );
endmodule
`default_nettype wire
